[src/mexp_pkg.sv]
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types for the modular exponentiation block: sequencer states,
// multiplication kinds and the control word of the multiplier cell row.
// ----------------------------------------------------------------------------
package mexp_pkg;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_WB,
    S_DONE
  } mexp_state_t;

  typedef enum logic [1:0] {
    OP_REDUCE,
    OP_ACC,
    OP_SQ
  } mexp_op_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic add_en;
  } mexp_cell_ctl_t;

endpackage

[src/mexp_if.sv]
// ----------------------------------------------------------------------------
// mexp channel interfaces
// Valid/ready channels for the operand items and the result items.
// ----------------------------------------------------------------------------
interface mexp_in_if #(parameter int WIDTH = 32);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] base;
  logic [WIDTH-1:0] exponent;
  logic [WIDTH-1:0] modulus;

  modport source (output valid, base, exponent, modulus, input ready);
  modport sink   (input valid, base, exponent, modulus, output ready);
endinterface

interface mexp_out_if #(parameter int WIDTH = 32);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] power_mod;
  logic             mod_zero_error;

  modport source (output valid, power_mod, mod_zero_error, input ready);
  modport sink   (input valid, power_mod, mod_zero_error, output ready);
endinterface

[src/modular_exponentiation_top.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// Computes base^exponent mod modulus by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// One item at a time. Every modular product runs through a row of WIDTH
// bit cells, one multiplier bit per cycle, followed by a write-back state.
// A zero modulus returns the error result in the cycle after the item is
// taken. The next item is taken once the result has been transferred.
module modular_exponentiation_top #(
  parameter int WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  mexp_in_if.sink    in_ch,
  mexp_out_if.source out_ch
);
  import mexp_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);
  localparam int BW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  mexp_state_t      state_r, state_nxt;
  mexp_op_t         op_r, op_nxt;
  logic [WIDTH-1:0] x_r, x_nxt, y_r, y_nxt, m_r, m_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt, sq_r, sq_nxt, e_r, e_nxt;
  logic [CW-1:0]    step_cnt_r, step_cnt_nxt;
  logic [BW-1:0]    bit_cnt_r, bit_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0] power_mod_r, power_mod_nxt;
  logic             err_r, err_nxt;
  mexp_cell_ctl_t   ctl;
  logic [WIDTH-1:0] prod;
  logic             in_xfer;

  mexp_mul_row #(.WIDTH(WIDTH)) u_row (
    .clk  (clk),
    .ctl  (ctl),
    .x    (x_r),
    .m    (m_r),
    .prod (prod)
  );

  assign in_ch.ready           = (state_r == S_IDLE);
  assign in_xfer               = in_ch.valid && in_ch.ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.power_mod      = power_mod_r;
  assign out_ch.mod_zero_error = err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      op_r        <= OP_REDUCE;
      step_cnt_r  <= '0;
      bit_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      op_r        <= op_nxt;
      step_cnt_r  <= step_cnt_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    m_r         <= m_nxt;
    acc_r       <= acc_nxt;
    sq_r        <= sq_nxt;
    e_r         <= e_nxt;
    power_mod_r <= power_mod_nxt;
    err_r       <= err_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    m_nxt         = m_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    e_nxt         = e_r;
    step_cnt_nxt  = step_cnt_r;
    bit_cnt_nxt   = bit_cnt_r;
    out_valid_nxt = out_valid_r;
    power_mod_nxt = power_mod_r;
    err_nxt       = err_r;
    ctl           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          m_nxt = in_ch.modulus;
          if (in_ch.modulus == '0) begin
            power_mod_nxt = '0;
            err_nxt       = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_DONE;
          end else begin
            x_nxt        = {{(WIDTH-1){1'b0}}, 1'b1};
            y_nxt        = in_ch.base;
            acc_nxt      = {{(WIDTH-1){1'b0}}, (in_ch.modulus != WIDTH'(1))};
            e_nxt        = in_ch.exponent;
            op_nxt       = OP_REDUCE;
            bit_cnt_nxt  = '0;
            step_cnt_nxt = CW'(WIDTH);
            ctl.clear    = 1'b1;
            state_nxt    = S_MUL;
          end
        end
      end
      S_MUL: begin
        ctl.step     = 1'b1;
        ctl.add_en   = y_r[WIDTH-1];
        y_nxt        = {y_r[WIDTH-2:0], 1'b0};
        step_cnt_nxt = step_cnt_r - CW'(1);
        if (step_cnt_r == CW'(1)) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        case (op_r)
          OP_ACC:  acc_nxt = prod;
          default: sq_nxt  = prod;
        endcase
        if (op_r == OP_ACC) begin
          op_nxt = OP_SQ;
        end else if (op_r == OP_SQ) begin
          e_nxt       = {1'b0, e_r[WIDTH-1:1]};
          bit_cnt_nxt = bit_cnt_r + BW'(1);
          op_nxt      = e_r[1] ? OP_ACC : OP_SQ;
        end else begin
          op_nxt = e_r[0] ? OP_ACC : OP_SQ;
        end
        if (op_r == OP_SQ && bit_cnt_r == BW'(WIDTH - 1)) begin
          power_mod_nxt = acc_r;
          err_nxt       = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          x_nxt        = (op_nxt == OP_ACC) ? acc_nxt : sq_nxt;
          y_nxt        = sq_nxt;
          step_cnt_nxt = CW'(WIDTH);
          ctl.clear    = 1'b1;
          state_nxt    = S_MUL;
        end
      end
      S_DONE: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && err_r |-> power_mod_r == '0)
    else $error("error result carries a non-zero value");

  a_zero_mod: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_ch.modulus == '0 |=> out_valid_r && err_r)
    else $error("zero modulus did not give the error result");

  a_prod_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WB |-> prod < m_r)
    else $error("modular product not below modulus");

  a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_DONE)
    else $error("result shown outside the done state");

endmodule

[src/mexp_cell.sv]
// ----------------------------------------------------------------------------
// mexp_cell
// One bit slice of the interleaved modular multiplier: holds one accumulator
// bit, takes the doubled bit from its lower neighbour and ripples the borrow
// and carry of the conditional subtract and add stages to its upper one.
// ----------------------------------------------------------------------------
module mexp_cell (
  input  logic                    clk,
  input  mexp_pkg::mexp_cell_ctl_t ctl,
  input  logic                    dbl_in,
  input  logic                    m_bit,
  input  logic                    x_bit,
  input  logic                    sel_dbl,
  input  logic                    sel_add,
  input  logic                    b1_in,
  input  logic                    c2_in,
  input  logic                    b3_in,
  output logic                    b1_out,
  output logic                    c2_out,
  output logic                    b3_out,
  output logic                    acc_bit
);
  import mexp_pkg::*;

  logic acc_r;
  logic acc_nxt;
  logic t1, r, u, v;

  always_comb begin
    t1      = dbl_in ^ m_bit ^ b1_in;
    b1_out  = (~dbl_in & m_bit) | (~(dbl_in ^ m_bit) & b1_in);
    r       = sel_dbl ? t1 : dbl_in;
    u       = r ^ x_bit ^ c2_in;
    c2_out  = (r & x_bit) | (c2_in & (r ^ x_bit));
    v       = u ^ m_bit ^ b3_in;
    b3_out  = (~u & m_bit) | (~(u ^ m_bit) & b3_in);
    acc_nxt = sel_add ? v : u;
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_r <= 1'b0;
    end else if (ctl.step) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc_bit = acc_r;

endmodule

[src/mexp_mul_row.sv]
// ----------------------------------------------------------------------------
// mexp_mul_row
// Row of WIDTH cells forming a shift-and-add modular multiplier: each step
// doubles the accumulator mod m, then adds x mod m when the multiplier bit
// is set.
// ----------------------------------------------------------------------------
module mexp_mul_row #(
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  mexp_pkg::mexp_cell_ctl_t ctl,
  input  logic [WIDTH-1:0]         x,
  input  logic [WIDTH-1:0]         m,
  output logic [WIDTH-1:0]         prod
);
  import mexp_pkg::*;

  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] dbl;
  logic [WIDTH-1:0] xg;
  logic [WIDTH:0]   b1, c2, b3;
  logic             sel_dbl, sel_add;

  assign dbl     = {acc[WIDTH-2:0], 1'b0};
  assign xg      = ctl.add_en ? x : '0;
  assign b1[0]   = 1'b0;
  assign c2[0]   = 1'b0;
  assign b3[0]   = 1'b0;
  assign sel_dbl = acc[WIDTH-1] | ~b1[WIDTH];
  assign sel_add = c2[WIDTH] | ~b3[WIDTH];

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    mexp_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .dbl_in  (dbl[i]),
      .m_bit   (m[i]),
      .x_bit   (xg[i]),
      .sel_dbl (sel_dbl),
      .sel_add (sel_add),
      .b1_in   (b1[i]),
      .c2_in   (c2[i]),
      .b3_in   (b3[i]),
      .b1_out  (b1[i+1]),
      .c2_out  (c2[i+1]),
      .b3_out  (b3[i+1]),
      .acc_bit (acc[i])
    );
  end

  assign prod = acc;

endmodule
